// ----- rtl/core/rct_pkg.sv -----
// Shared types and constants for the replay check node table.
// Holds table sizing, entry layout and verdict codes; no dependencies.
package rct_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  localparam int AddrW   = 64;
  localparam int FcW     = 32;
  localparam int KcW     = 8;
  localparam int OutIdxW = 3;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [FcW-1:0]   fc;
    logic [KcW-1:0]   kc;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    VerdictKnown    = 3'd0,
    VerdictNew      = 3'd1,
    VerdictReplay   = 3'd2,
    VerdictAuthFail = 3'd3,
    VerdictFull     = 3'd4
  } verdict_e;

  // Low bits of an entry number as reported on the result port.
  function automatic logic [OutIdxW-1:0] out_index(input logic [IdxW-1:0] idx);
    logic [IdxW+OutIdxW-1:0] wide;
    wide = {{OutIdxW{1'b0}}, idx};
    return wide[OutIdxW-1:0];
  endfunction

endpackage

// ----- rtl/core/rct_ram.sv -----
// Generic single-port RAM with registered read data.
// Used for the sender table storage; no package dependencies.
module rct_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/replay_check_node_table.sv -----
// Flow: an accepted transaction starts a scan from entry 0; a match ends the scan,
// else the scan runs to the last entry; a verdict state then registers the result.
// Throughput: one frame at a time; the single table read port scanned one entry per
// cycle sets the rate. Input ready is low from acceptance until the result is taken.
// Reset: asynchronous, active low; clears all entry used bits and the sequencer.
// Depends on rct_pkg and rct_ram.
module replay_check_node_table
  import rct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [AddrW-1:0]   sender_address_i,
  input  logic [FcW-1:0]     frame_count_i,
  input  logic [KcW-1:0]     key_count_i,
  input  logic               auth_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         verdict_o,
  output logic [OutIdxW-1:0] entry_index_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StHit,
    StMiss,
    StOut
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      scan_q;
  logic                 cmp_vld_q;
  logic                 cmp_used_q;
  logic [IdxW-1:0]      cmp_idx_q;
  logic                 free_found_q;
  logic [IdxW-1:0]      free_idx_q;
  logic [IdxW-1:0]      hit_idx_q;
  entry_t               hit_entry_q;
  logic [TABLE_ENTRIES-1:0] used_q;
  logic [AddrW-1:0]     addr_q;
  logic [FcW-1:0]       fc_q;
  logic [KcW-1:0]       kc_q;
  logic                 auth_q;
  verdict_e             verdict_q;
  logic [OutIdxW-1:0]   index_q;

  logic            issue;
  logic [IdxW-1:0] scan_idx;
  logic            hit;
  logic            last_cmp;
  logic            replay;
  logic            ram_we;
  logic            ram_en;
  logic [IdxW-1:0] ram_addr;
  entry_t          ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  entry_t          rd_entry;

  assign scan_idx = scan_q[IdxW-1:0];
  assign issue    = (state_q == StScan) && (scan_q < CntW'(TABLE_ENTRIES));
  assign rd_entry = entry_t'(ram_rdata);
  assign hit      = cmp_vld_q && cmp_used_q && (rd_entry.addr == addr_q);
  assign last_cmp = cmp_vld_q && (cmp_idx_q == IdxW'(TABLE_ENTRIES - 1));
  assign replay   = (hit_entry_q.fc > fc_q) || (hit_entry_q.fc == {FcW{1'b1}});

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_idx;
    ram_wdata = '{addr: addr_q, fc: fc_q, kc: kc_q};
    case (state_q)
      StHit: begin
        ram_we    = !replay;
        ram_addr  = hit_idx_q;
        // keep the key counter from entry creation
        ram_wdata = '{addr: addr_q, fc: fc_q, kc: hit_entry_q.kc};
      end
      StMiss: begin
        ram_we   = auth_q && free_found_q;
        ram_addr = free_idx_q;
      end
      default: ;
    endcase
  end

  assign ram_en = issue || ram_we;

  rct_ram #(
    .Width(EntryW),
    .Depth(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_used_q   <= 1'b0;
      cmp_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      hit_idx_q    <= '0;
      hit_entry_q  <= '0;
      used_q       <= '0;
      addr_q       <= '0;
      fc_q         <= '0;
      kc_q         <= '0;
      auth_q       <= 1'b0;
      verdict_q    <= VerdictKnown;
      index_q      <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            addr_q       <= sender_address_i;
            fc_q         <= frame_count_i;
            kc_q         <= key_count_i;
            auth_q       <= auth_ok_i;
            scan_q       <= '0;
            cmp_vld_q    <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= StScan;
          end
        end
        StScan: begin
          // read stage: issue next entry, note the lowest free slot
          cmp_vld_q  <= issue;
          cmp_idx_q  <= scan_idx;
          cmp_used_q <= used_q[scan_idx];
          if (issue) begin
            scan_q <= scan_q + 1'b1;
            if (!used_q[scan_idx] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= scan_idx;
            end
          end
          // compare stage: one entry behind the read stage
          if (hit) begin
            hit_idx_q   <= cmp_idx_q;
            hit_entry_q <= rd_entry;
            state_q     <= StHit;
          end else if (last_cmp) begin
            state_q <= StMiss;
          end
        end
        StHit: begin
          index_q <= out_index(hit_idx_q);
          if (replay) begin
            verdict_q <= VerdictReplay;
          end else if (auth_q) begin
            verdict_q <= VerdictKnown;
          end else begin
            verdict_q <= VerdictAuthFail;
          end
          state_q <= StOut;
        end
        StMiss: begin
          index_q <= '0;
          if (!auth_q) begin
            verdict_q <= VerdictAuthFail;
          end else if (free_found_q) begin
            used_q[free_idx_q] <= 1'b1;
            verdict_q          <= VerdictNew;
            index_q            <= out_index(free_idx_q);
          end else begin
            verdict_q <= VerdictFull;
          end
          state_q <= StOut;
        end
        StOut: begin
          if (out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign verdict_o     = verdict_q;
  assign entry_index_o = index_q;

endmodule
